>>> design/bis_pkg.sv
package bis_pkg;

    localparam int VALUE_W   = 32;
    localparam int COUNT_W   = 5;
    localparam int STATUS_W  = 3;
    localparam int DEPTH_DEF = 16;

    localparam logic [COUNT_W-1:0] CAP_RESET = COUNT_W'(16);

    typedef enum logic [STATUS_W-1:0] {
        ST_ADDED     = 3'd0,
        ST_PRESENT   = 3'd1,
        ST_FULL      = 3'd2,
        ST_REMOVED   = 3'd3,
        ST_NOT_FOUND = 3'd4
    } t_status;

    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_REMOVE = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic    load;
        logic    step;
        logic    shift_init;
        logic    shift_run;
        logic    append;
        logic    dec;
        logic    finish;
        t_status status;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic hit;
        logic done;
        logic full;
    } t_dp_stat;

endpackage

>>> design/bis_ram.sv
module bis_ram import bis_pkg::*; #(
    parameter int WIDTH = VALUE_W,
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/bis_datapath.sv
module bis_datapath import bis_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic signed [VALUE_W-1:0]  i_value,
    input  logic                       i_cap_we,
    input  logic [COUNT_W-1:0]         i_cap_wdata,
    input  t_dp_cmd                    i_cmd,
    output t_dp_stat                   o_stat,
    output logic                       o_done,
    output logic [STATUS_W-1:0]        o_status,
    output logic [COUNT_W-1:0]         o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic signed [VALUE_W-1:0] r_value;
    logic [COUNT_W-1:0]        r_count;
    logic [COUNT_W-1:0]        n_count;
    logic [COUNT_W-1:0]        r_cap;
    logic [COUNT_W-1:0]        r_rd_idx;
    logic [COUNT_W-1:0]        r_cmp_idx;
    logic [COUNT_W-1:0]        r_wr_idx;
    logic                      r_cmp_v;
    logic                      r_done;
    t_status                   r_status;
    logic [COUNT_W-1:0]        r_res_count;

    logic               issue;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr;
    logic [VALUE_W-1:0] ram_wdata;
    logic [AW-1:0]      ram_raddr;
    logic [VALUE_W-1:0] ram_rdata;

    bis_ram #(
        .WIDTH (VALUE_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // A read is issued while the read pointer is still below the count.
    assign issue     = (r_rd_idx < r_count);
    assign ram_raddr = AW'(r_rd_idx);
    assign ram_we    = i_cmd.append || (i_cmd.shift_run && r_cmp_v);
    assign ram_waddr = i_cmd.append ? AW'(r_count) : AW'(r_wr_idx);
    assign ram_wdata = i_cmd.append ? r_value : ram_rdata;

    always_comb begin
        n_count = r_count;
        if (i_cmd.append) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.dec) begin
            n_count = r_count - 1'b1;
        end
    end

    assign o_stat.hit  = r_cmp_v && (ram_rdata == r_value);
    assign o_stat.done = !r_cmp_v && !issue;
    assign o_stat.full = (r_count >= r_cap) || (int'(r_count) >= DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_cap   <= CAP_RESET;
            r_cmp_v <= 1'b0;
            r_done  <= 1'b0;
        end else begin
            r_count <= n_count;
            r_done  <= i_cmd.finish;
            if (i_cap_we) begin
                r_cap <= i_cap_wdata;
            end
            if (i_cmd.load) begin
                r_rd_idx <= '0;
                r_cmp_v  <= 1'b0;
            end else if (i_cmd.shift_init) begin
                r_rd_idx <= r_cmp_idx + 1'b1;
                r_wr_idx <= r_cmp_idx;
                r_cmp_v  <= 1'b0;
            end else if (i_cmd.step) begin
                if (issue) begin
                    r_rd_idx  <= r_rd_idx + 1'b1;
                    r_cmp_idx <= r_rd_idx;
                    r_cmp_v   <= 1'b1;
                end else begin
                    r_cmp_v <= 1'b0;
                end
                if (i_cmd.shift_run && r_cmp_v) begin
                    r_wr_idx <= r_wr_idx + 1'b1;
                end
            end
        end
        if (i_cmd.load) begin
            r_value <= i_value;
        end
        if (i_cmd.finish) begin
            r_status    <= i_cmd.status;
            r_res_count <= n_count;
        end
    end

    assign o_done   = r_done;
    assign o_status = r_status;
    assign o_count  = r_res_count;

endmodule

>>> design/bis_ctrl.sv
module bis_ctrl import bis_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     start,
    input  logic     i_mode,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     busy
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_busy;
    logic   r_mode;
    logic   accept;

    assign accept = start && !r_busy;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.status = ST_ADDED;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.step = 1'b1;
                if (i_stat.hit) begin
                    if (r_mode == MODE_REMOVE) begin
                        o_cmd.step       = 1'b0;
                        o_cmd.shift_init = 1'b1;
                        n_state          = S_SHIFT;
                    end else begin
                        o_cmd.finish = 1'b1;
                        o_cmd.status = ST_PRESENT;
                        n_state      = S_IDLE;
                    end
                end else if (i_stat.done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                    if (r_mode == MODE_REMOVE) begin
                        o_cmd.status = ST_NOT_FOUND;
                    end else if (i_stat.full) begin
                        o_cmd.status = ST_FULL;
                    end else begin
                        o_cmd.append = 1'b1;
                        o_cmd.status = ST_ADDED;
                    end
                end
            end
            S_SHIFT: begin
                o_cmd.step      = 1'b1;
                o_cmd.shift_run = 1'b1;
                if (i_stat.done) begin
                    o_cmd.dec    = 1'b1;
                    o_cmd.finish = 1'b1;
                    o_cmd.status = ST_REMOVED;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_busy  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_busy  <= (n_state != S_IDLE);
        end
        if (accept) begin
            r_mode <= i_mode;
        end
    end

    assign busy = r_busy;

endmodule

>>> design/bounded_integer_set_table.sv
// A search scans the held entries until a hit or the end of the set; an insert of a held value
// ends at its hit, and a remove that hits adds a shift pass over the entries behind it.
// The next transaction can be taken in the cycle that shows the result; transactions do not
// overlap, as the entry RAM's single read port is shared by search and shift.
// Reset (i_rst_n low, synchronous) empties the set and sets capacity to 16.
// The receiver cannot stall: each result is shown for one cycle only.
module bounded_integer_set_table import bis_pkg::*; #(
    parameter int DEPTH = DEPTH_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    input  logic                      i_mode,
    input  logic signed [VALUE_W-1:0] i_value,
    output logic                      busy,
    input  logic                      i_cap_we,
    input  logic [COUNT_W-1:0]        i_cap_wdata,
    output logic                      o_done,
    output logic [STATUS_W-1:0]       o_status,
    output logic [COUNT_W-1:0]        o_count
);

    // The controller sequences each transaction through a search pass and, for a
    // removal that hits, a shift pass. The datapath owns the entry RAM, the held
    // count, the capacity register and the result registers.
    // A removal that hits the last entry has nothing to shift and writes no entry in its shift pass.
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    bis_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_mode  (i_mode),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .busy    (busy)
    );

    // The search reads one entry per cycle; the compare sees the registered read
    // data in the next cycle, so reads and compares overlap. The shift reads entry
    // k + 2 while it writes entry k + 1, read the cycle before, into place k.
    bis_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cap_we    (i_cap_we),
        .i_cap_wdata (i_cap_wdata),
        .i_cmd       (dp_cmd),
        .o_stat      (dp_stat),
        .o_done      (o_done),
        .o_status    (o_status),
        .o_count     (o_count)
    );

    // A result only ever ends a transaction that was in progress.
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(busy))
        else $error("result without a transaction in progress");

    // Every transaction that finishes produces exactly one result at once.
    a_fall_gives_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(busy) |-> o_done)
        else $error("transaction ended without a result");

    // A value that was just added leaves the set non-empty and within its depth.
    a_added_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status == ST_ADDED)) |->
            ((o_count != '0) && (int'(o_count) <= DEPTH)))
        else $error("count inconsistent after an insertion");

endmodule
